// ===== rtl/lgov_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgov_pkg
// Shared widths, register codes and payload types of the load governor core.
// ----------------------------------------------------------------------------
package lgov_pkg;

  localparam int unsigned FreqBits  = 24;
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned DwellBits = 27;
  localparam int unsigned PctBits   = 7;
  localparam int unsigned TaskBits  = 8;
  localparam int unsigned LoadBits  = 7;
  localparam int unsigned CfgBits   = 27;
  localparam int unsigned IdxBits   = 3;

  // Numerator of the load division: 100 * busy time, below 128 * wall.
  localparam int unsigned NumW      = TimeBits + LoadBits;
  // Scale-down product: frequency times (load + bias), bias sum below 256.
  localparam int unsigned ProdW     = FreqBits + 8;
  // Reciprocal of the divide by 75, scaled by 2^(ProdW + 6).
  localparam int unsigned RecipShift = ProdW + 6;
  // Wide frequency domain for candidates before clamping.
  localparam int unsigned FW        = FreqBits + 2;

  localparam int unsigned Hundred   = 100;
  localparam int unsigned ScaleDiv  = 75;
  localparam logic [ProdW-1:0] Recip = ProdW'((64'd1 << RecipShift) / 64'd75);

  localparam int unsigned InDataBits  = ((3 * FreqBits + 1 + TaskBits + 2 * TimeBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = ((1 + FreqBits + LoadBits + 7) / 8) * 8;

  typedef enum logic [IdxBits-1:0] {
    RegDownDwell  = 3'd0,
    RegWakeFloor  = 3'd1,
    RegSleepCap   = 3'd2,
    RegUpStep     = 3'd3,
    RegDownLimit  = 3'd4,
    RegHighPct    = 3'd5,
    RegLowPct     = 3'd6
  } reg_idx_e;

  typedef enum logic {
    OpForcedUp = 1'b0,
    OpEvaluate = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   opcode;
    logic [FreqBits-1:0]   cur;
    logic [FreqBits-1:0]   lo;
    logic [FreqBits-1:0]   hi;
    logic                  susp;
    logic [TaskBits-1:0]   tasks;
    logic [TimeBits-1:0]   wall;
  } evt_t;

  typedef struct packed {
    evt_t                  evt;
    logic                  ok;
    logic [NumW-1:0]       rem;
    logic [LoadBits-1:0]   quo;
  } div_t;

  typedef struct packed {
    evt_t                  evt;
    logic [LoadBits-1:0]   load;
    logic [ProdW-1:0]      prod;
    logic [FW-1:0]         ramp;
    logic [FW-1:0]         q;
  } scl_t;

endpackage

// ===== rtl/dvfs_load_governor_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvfs_load_governor_step_core
// Load-threshold frequency governor, one evaluation per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one evaluation per beat: tuser holds the opcode (forced
//   ramp-up or load evaluation), tdata the frequencies, suspend flag, task
//   count and the idle/wall times. m_axis returns exactly one result beat per
//   input beat, in order: apply flag, target frequency and measured load.
//   The cfg channel writes the tuning registers by index; it is always ready
//   and is meant to be used only while no beat is in flight.
// Pipeline:
//   13 register stages: input stage, seven one-bit restoring division
//   stages for the load, three stages for the scale-down product and the
//   divide by 75 (reciprocal multiply plus correction), a selection stage and
//   the output register; one beat is accepted per cycle unless stalled.
// Reset clears all valid bits and loads the register defaults. When the
// receiver stalls, beats collect in empty stages and tready drops only once
// every stage holds a beat.
// ----------------------------------------------------------------------------
module dvfs_load_governor_step_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // cfg channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lgov_pkg::IdxBits-1:0]       cfg_index_i,
  input  logic [lgov_pkg::CfgBits-1:0]       cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low to high: cur_khz, floor_khz, ceiling_khz, is_suspended,
  // runnable_tasks, idle_since_change_us, wall_since_change_us, zero pad
  input  logic [lgov_pkg::InDataBits-1:0]    s_axis_tdata,
  // tuser: opcode
  input  logic                               s_axis_tuser,
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low to high: apply, target_khz, load_pct
  output logic [lgov_pkg::OutDataBits-1:0]   m_axis_tdata
);
  import lgov_pkg::*;

  localparam int unsigned DivSteps = LoadBits;

  typedef struct packed {
    evt_t                evt;
    logic [LoadBits-1:0] load;
    logic                apply;
    logic [FW-1:0]       f;
  } sel_t;

  // Tuning registers
  logic [DwellBits-1:0] dwell_q;
  logic [FreqBits-1:0]  wake_q, cap_q, up_q, dlim_q;
  logic [PctBits-1:0]   high_q, low_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= DwellBits'(48000);
      wake_q  <= FreqBits'(921600);
      cap_q   <= FreqBits'(249600);
      up_q    <= FreqBits'(100000);
      dlim_q  <= FreqBits'(200000);
      high_q  <= PctBits'(70);
      low_q   <= PctBits'(35);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegDownDwell: dwell_q <= cfg_data_i[DwellBits-1:0];
        RegWakeFloor: wake_q  <= cfg_data_i[FreqBits-1:0];
        RegSleepCap:  cap_q   <= cfg_data_i[FreqBits-1:0];
        RegUpStep:    up_q    <= cfg_data_i[FreqBits-1:0];
        RegDownLimit: dlim_q  <= cfg_data_i[FreqBits-1:0];
        RegHighPct:   high_q  <= cfg_data_i[PctBits-1:0];
        RegLowPct:    low_q   <= cfg_data_i[PctBits-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Input stage: unpack, form 100 * busy time for the divider
  evt_t                in_evt;
  logic [TimeBits-1:0] in_idle;
  logic [TimeBits-1:0] busy;
  div_t                a_d, a_q;
  logic                a_valid_q, a_ready;

  always_comb begin
    in_evt.opcode = op_e'(s_axis_tuser);
    in_evt.cur    = s_axis_tdata[FreqBits-1:0];
    in_evt.lo     = s_axis_tdata[2*FreqBits-1:FreqBits];
    in_evt.hi     = s_axis_tdata[3*FreqBits-1:2*FreqBits];
    in_evt.susp   = s_axis_tdata[3*FreqBits];
    in_evt.tasks  = s_axis_tdata[3*FreqBits+TaskBits:3*FreqBits+1];
    in_evt.wall   = s_axis_tdata[3*FreqBits+TaskBits+2*TimeBits:3*FreqBits+TaskBits+TimeBits+1];
  end
  assign in_idle = s_axis_tdata[3*FreqBits+TaskBits+TimeBits:3*FreqBits+TaskBits+1];
  assign busy    = in_evt.wall - in_idle;

  always_comb begin
    a_d.evt = in_evt;
    // Zero wall time or idle beyond wall reads as no load.
    a_d.ok  = (in_evt.wall != '0) && (in_idle <= in_evt.wall);
    a_d.rem = a_d.ok ? NumW'(busy) * NumW'(Hundred) : '0;
    a_d.quo = '0;
  end

  assign s_axis_tready = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_q <= a_d;
    end
  end

  // Division chain: quotient bits from MSB down
  div_t            dv_data  [DivSteps+1];
  logic [DivSteps:0] dv_valid;
  logic [DivSteps:0] dv_ready;

  assign dv_data[0]  = a_q;
  assign dv_valid[0] = a_valid_q;
  assign a_ready     = dv_ready[0];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    lgov_div_stage #(
      .Shift(DivSteps - 1 - k)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (dv_valid[k]),
      .in_ready_o (dv_ready[k]),
      .in_i       (dv_data[k]),
      .out_valid_o(dv_valid[k+1]),
      .out_ready_i(dv_ready[k+1]),
      .out_o      (dv_data[k+1])
    );
  end

  // Scale-down path
  scl_t sc_in, sc_out;
  logic sc_valid, sc_ready;

  always_comb begin
    sc_in      = '0;
    sc_in.evt  = dv_data[DivSteps].evt;
    sc_in.load = dv_data[DivSteps].ok ? dv_data[DivSteps].quo : '0;
  end

  lgov_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .high_pct_i (high_q),
    .up_step_i  (up_q),
    .in_valid_i (dv_valid[DivSteps]),
    .in_ready_o (dv_ready[DivSteps]),
    .in_i       (sc_in),
    .out_valid_o(sc_valid),
    .out_ready_i(sc_ready),
    .out_o      (sc_out)
  );

  // Selection stage: hold decision and raw target
  sel_t                sel_d, sel_q;
  logic                sel_valid_q, sel_ready;
  logic                dl_on;
  logic [FreqBits-1:0] dl_floor;
  logic [FW-1:0]       f_down;

  assign dl_on    = (dlim_q != '0) && (dlim_q < sc_out.evt.cur);
  assign dl_floor = sc_out.evt.cur - dlim_q;
  assign f_down   = (dl_on && (sc_out.q < FW'(dl_floor))) ? FW'(dl_floor) : sc_out.q;

  always_comb begin
    sel_d.evt  = sc_out.evt;
    sel_d.load = sc_out.load;
    if (sc_out.evt.opcode == OpForcedUp) begin
      sel_d.load  = '0;
      sel_d.apply = !((sc_out.evt.cur == sc_out.evt.hi) || (sc_out.evt.tasks <= TaskBits'(1)));
      sel_d.f     = sc_out.ramp;
    end else begin
      sel_d.apply = !((sc_out.evt.cur == sc_out.evt.lo) ||
                      (sc_out.evt.wall < TimeBits'(dwell_q)));
      priority if (sc_out.load < low_q) begin
        sel_d.f = f_down;
      end else if (sc_out.load > high_q) begin
        sel_d.f = sc_out.ramp;
      end else begin
        sel_d.f = FW'(sc_out.evt.cur);
      end
    end
  end

  assign sc_ready = !sel_valid_q || sel_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else if (sc_ready) begin
      sel_valid_q <= sc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_valid && sc_ready) begin
      sel_q <= sel_d;
    end
  end

  // Output stage: sleep cap or wake floor, then ceiling and floor clamp; current frequency if not applied
  logic          capped;
  logic [FW-1:0] f_cap, f_hi, f_out;
  logic          out_valid_q;
  logic [FreqBits-1:0] tgt_q;
  logic [LoadBits-1:0] load_q;
  logic                apply_q;
  evt_t                oevt_q;

  assign capped = sel_q.evt.susp && (cap_q != '0);

  always_comb begin
    if (sel_q.evt.opcode == OpForcedUp) begin
      if (capped) begin
        f_cap = (sel_q.f > FW'(cap_q)) ? FW'(cap_q) : sel_q.f;
      end else begin
        f_cap = (sel_q.f < FW'(wake_q)) ? FW'(wake_q) : sel_q.f;
      end
    end else begin
      f_cap = (capped && ((sel_q.f > FW'(cap_q)) || (sel_q.f > FW'(sel_q.evt.cur))))
              ? FW'(cap_q) : sel_q.f;
    end
    f_hi = (f_cap > FW'(sel_q.evt.hi)) ? FW'(sel_q.evt.hi) : f_cap;
    if (!sel_q.apply) begin
      f_out = FW'(sel_q.evt.cur);
    end else begin
      f_out = (f_hi < FW'(sel_q.evt.lo)) ? FW'(sel_q.evt.lo) : f_hi;
    end
  end

  assign sel_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sel_ready) begin
      out_valid_q <= sel_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_valid_q && sel_ready) begin
      tgt_q   <= f_out[FreqBits-1:0];
      load_q  <= sel_q.load;
      apply_q <= sel_q.apply;
      oevt_q  <= sel_q.evt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataBits'({load_q, tgt_q, apply_q});

  // Checks
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (load_q <= LoadBits'(Hundred)))
    else $error("load above 100 percent");

  a_forced_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (oevt_q.opcode == OpForcedUp)) |-> (load_q == '0))
    else $error("forced ramp-up reports nonzero load");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && apply_q && (oevt_q.lo <= oevt_q.hi)) |->
      ((tgt_q >= oevt_q.lo) && (tgt_q <= oevt_q.hi)))
    else $error("applied target outside policy limits");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

endmodule

// ===== rtl/lgov_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgov_div_stage
// One restoring step of the load division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lgov_div_stage #(
  parameter int unsigned Shift = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lgov_pkg::div_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lgov_pkg::div_t out_o
);
  import lgov_pkg::*;

  logic            valid_q;
  div_t            data_q, data_d;
  logic [NumW-1:0] dsh;
  logic            ge;

  assign dsh = NumW'(in_i.evt.wall) << Shift;
  assign ge  = in_i.rem >= dsh;

  always_comb begin
    data_d     = in_i;
    data_d.rem = ge ? in_i.rem - dsh : in_i.rem;
    data_d.quo = {in_i.quo[LoadBits-2:0], ge};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/lgov_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgov_scale
// Three-stage scale-down path: product, reciprocal multiply, remainder fix.
// ----------------------------------------------------------------------------
module lgov_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lgov_pkg::PctBits-1:0]  high_pct_i,
  input  logic [lgov_pkg::FreqBits-1:0] up_step_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lgov_pkg::scl_t                in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lgov_pkg::scl_t                out_o
);
  import lgov_pkg::*;

  logic [2:0]         valid_q;
  logic [2:0]         rdy;
  scl_t               s_q [3];
  scl_t               s_d [3];
  logic [PctBits-1:0] bias;
  logic [7:0]         factor;
  logic [2*ProdW-1:0] wide;
  logic [ProdW-1:0]   chk;
  logic [ProdW-1:0]   rem;

  assign rdy[2]      = !valid_q[2] || out_ready_i;
  assign rdy[1]      = !valid_q[1] || rdy[2];
  assign rdy[0]      = !valid_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[2];
  assign out_o       = s_q[2];

  assign bias   = (high_pct_i < PctBits'(Hundred)) ? PctBits'(Hundred) - high_pct_i : '0;
  assign factor = 8'(in_i.load) + 8'(bias);
  assign wide   = {{ProdW{1'b0}}, s_q[0].prod} * {{ProdW{1'b0}}, Recip};
  assign chk    = ProdW'(s_q[1].q) * ProdW'(ScaleDiv);
  assign rem    = s_q[1].prod - chk;

  always_comb begin
    s_d[0]      = in_i;
    s_d[0].prod = ProdW'(in_i.evt.cur) * ProdW'(factor);
    s_d[0].ramp = (up_step_i != '0) ? FW'(in_i.evt.cur) + FW'(up_step_i) : FW'(in_i.evt.hi);
    s_d[0].q    = '0;

    // Estimate may fall one short of the true quotient.
    s_d[1]      = s_q[0];
    s_d[1].q    = wide[2*ProdW-1:RecipShift];

    s_d[2]      = s_q[1];
    s_d[2].q    = (rem >= ProdW'(ScaleDiv)) ? s_q[1].q + FW'(1) : s_q[1].q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy[0]) s_q[0] <= s_d[0];
    if (valid_q[0] && rdy[1]) s_q[1] <= s_d[1];
    if (valid_q[1] && rdy[2]) s_q[2] <= s_d[2];
  end

endmodule

// ===== tb/dvfs_load_governor_step_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvfs_load_governor_step_checker
// Watches the cfg, input and output channels of the governor core, predicts
// one result per accepted input beat and compares it field by field.
// ----------------------------------------------------------------------------
module dvfs_load_governor_step_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [lgov_pkg::IdxBits-1:0]       cfg_index_i,
  input  logic [lgov_pkg::CfgBits-1:0]       cfg_data_i,
  input  logic                               s_tvalid_i,
  input  logic                               s_tready_i,
  input  logic [lgov_pkg::InDataBits-1:0]    s_tdata_i,
  input  logic                               s_tuser_i,
  input  logic                               m_tvalid_i,
  input  logic                               m_tready_i,
  input  logic [lgov_pkg::OutDataBits-1:0]   m_tdata_i,
  output int                                 errors_o,
  output int                                 pending_o
);
  import lgov_pkg::*;

  typedef struct packed {
    logic                apply;
    logic [FreqBits-1:0] target;
    logic [LoadBits-1:0] load;
  } verdict_t;

  logic [DwellBits-1:0] dwell_us;
  logic [FreqBits-1:0]  wake_floor, sleep_cap, up_step, down_limit;
  logic [PctBits-1:0]   high_pct, low_pct;

  verdict_t target_fifo[$];

  function automatic verdict_t govern(op_e op, logic [63:0] cur, logic [63:0] lo,
                                      logic [63:0] hi, logic susp, logic [63:0] tasks,
                                      logic [63:0] idle, logic [63:0] wall);
    logic [63:0] load, f, bias;
    logic        capped, act;
    verdict_t    v;
    capped = susp && sleep_cap != 0;
    load   = 0;
    act    = 1'b1;
    if (op == OpForcedUp) begin
      if (cur == hi || tasks <= 1) begin
        act = 1'b0;
        f   = cur;
      end else begin
        f = (up_step != 0) ? cur + up_step : hi;
        if (capped) begin
          if (f > sleep_cap) f = sleep_cap;
        end else if (f < wake_floor) begin
          f = wake_floor;
        end
      end
    end else begin
      if (wall != 0 && idle <= wall) load = (100 * (wall - idle)) / wall;
      if (cur == lo || wall < dwell_us) begin
        act = 1'b0;
        f   = cur;
      end else begin
        if (load < low_pct) begin
          bias = (high_pct < 100) ? 100 - high_pct : 0;
          f    = (cur * (load + bias)) / 75;
          // limit the drop only when the limit is below the current frequency
          if (down_limit != 0 && down_limit < cur && f < cur - down_limit)
            f = cur - down_limit;
        end else if (load > high_pct) begin
          f = (up_step != 0) ? cur + up_step : hi;
        end else begin
          f = cur;
        end
        if (capped && (f > sleep_cap || f > cur)) f = sleep_cap;
      end
    end
    if (act) begin
      if (f > hi) f = hi;
      if (f < lo) f = lo;
    end
    v.apply  = act;
    v.target = f[FreqBits-1:0];
    v.load   = load[LoadBits-1:0];
    return v;
  endfunction

  assign pending_o = target_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want, got;
    int       bad;
    bad = 0;
    if (!rst_ni) begin
      dwell_us   <= DwellBits'(48000);
      wake_floor <= FreqBits'(921600);
      sleep_cap  <= FreqBits'(249600);
      up_step    <= FreqBits'(100000);
      down_limit <= FreqBits'(200000);
      high_pct   <= PctBits'(70);
      low_pct    <= PctBits'(35);
      errors_o   <= 0;
      target_fifo.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          RegDownDwell: dwell_us   <= cfg_data_i[DwellBits-1:0];
          RegWakeFloor: wake_floor <= cfg_data_i[FreqBits-1:0];
          RegSleepCap:  sleep_cap  <= cfg_data_i[FreqBits-1:0];
          RegUpStep:    up_step    <= cfg_data_i[FreqBits-1:0];
          RegDownLimit: down_limit <= cfg_data_i[FreqBits-1:0];
          RegHighPct:   high_pct   <= cfg_data_i[PctBits-1:0];
          RegLowPct:    low_pct    <= cfg_data_i[PctBits-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        target_fifo.push_back(govern(op_e'(s_tuser_i), s_tdata_i[23:0], s_tdata_i[47:24],
                                     s_tdata_i[71:48], s_tdata_i[72], s_tdata_i[80:73],
                                     s_tdata_i[112:81], s_tdata_i[144:113]));
      if (m_tvalid_i && m_tready_i) begin
        got.apply  = m_tdata_i[0];
        got.target = m_tdata_i[24:1];
        got.load   = m_tdata_i[31:25];
        if (target_fifo.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, m_tdata_i);
          bad++;
        end else begin
          want = target_fifo.pop_front();
          if (want.apply !== got.apply) begin
            $display("%0t: apply expected %0d actual %0d", $time, want.apply, got.apply);
            bad++;
          end
          if (want.target !== got.target) begin
            $display("%0t: target_khz expected %0d actual %0d", $time, want.target,
                     got.target);
            bad++;
          end
          if (want.load !== got.load) begin
            $display("%0t: load_pct expected %0d actual %0d", $time, want.load, got.load);
            bad++;
          end
        end
      end
      if (bad != 0) errors_o <= errors_o + bad;
    end
  end

endmodule

// ===== tb/tb_dvfs_load_governor_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dvfs_load_governor_step_core
// Drives directed and random governor evaluations through the core over
// several register settings, with bursty input and a stalling receiver; the
// checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_dvfs_load_governor_step_core;
  import lgov_pkg::*;

  localparam logic [IdxBits-1:0] RegUnmapped = 3'd7;
  localparam int ItemsPerPhase = 255;
  localparam int IdleLimit     = 3000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [IdxBits-1:0]     cfg_index_i = '0;
  logic [CfgBits-1:0]     cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  int                     errors, pending;
  int                     cycle_no, hold_left;
  int                     quiet_cycles = 0;
  logic [DwellBits-1:0]   dwell_now = DwellBits'(48000);

  always #10 clk_i = ~clk_i;

  dvfs_load_governor_step_core DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  dvfs_load_governor_step_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: the stall style rotates through four modes - always ready,
  // coin flips, rare single stalls, and long stall stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      cycle_no      <= 0;
      hold_left     <= 0;
    end else begin
      cycle_no <= cycle_no + 1;
      case ((cycle_no / 300) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: begin
          if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            hold_left     <= $urandom_range(5, 30);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Watchdog: end the run once no beat has moved for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one evaluation beat and hold it until accepted; valid stays high.
  task automatic send_eval(op_e op, logic [23:0] cur, logic [23:0] lo, logic [23:0] hi,
                           logic susp, logic [7:0] tasks, logic [31:0] idle,
                           logic [31:0] wall);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, wall, idle, tasks, susp, hi, lo, cur};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Write one register; valid stays high for back-to-back writes.
  task automatic write_reg(logic [IdxBits-1:0] idx, logic [CfgBits-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    if (idx == RegDownDwell) dwell_now = value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Drain the pipe, then load a full register set.
  task automatic load_settings(logic [CfgBits-1:0] dwell, logic [CfgBits-1:0] wake,
                               logic [CfgBits-1:0] cap, logic [CfgBits-1:0] step,
                               logic [CfgBits-1:0] lim, logic [CfgBits-1:0] high,
                               logic [CfgBits-1:0] low);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    write_reg(RegDownDwell, dwell);
    write_reg(RegWakeFloor, wake);
    write_reg(RegSleepCap, cap);
    write_reg(RegUpStep, step);
    write_reg(RegDownLimit, lim);
    write_reg(RegHighPct, high);
    write_reg(RegLowPct, low);
    write_reg(RegUnmapped, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // Random evaluations in bursts. Frequencies mostly sit in a realistic band
  // with frequent equal floor/ceiling hits; wall time hovers around the dwell.
  task automatic random_burst(int count);
    logic [23:0] cur, lo, hi;
    logic [31:0] idle, wall;
    logic [63:0] span;
    int          sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      while (burst > 0 && sent < count) begin
        if ($urandom_range(0, 3) == 0) begin
          cur = $urandom; lo = $urandom; hi = $urandom;
        end else begin
          cur = $urandom_range(100000, 3000000);
          lo  = $urandom_range(50000, 1200000);
          hi  = $urandom_range(800000, 3500000);
        end
        case ($urandom_range(0, 7))
          0: lo = cur;
          1: hi = cur;
          2: {lo, hi} = {hi, lo};
          default: ;
        endcase
        span = 64'(dwell_now) * 2 + 10;
        case ($urandom_range(0, 9))
          0: wall = $urandom;
          1: wall = 0;
          default: wall = (span > 64'hFFFF_FFFF) ? $urandom : $urandom_range(0, span);
        endcase
        case ($urandom_range(0, 7))
          0: idle = $urandom;
          1: idle = wall + $urandom_range(1, 1000);
          default: idle = 32'((64'(wall) * $urandom_range(0, 100)) / 100);
        endcase
        send_eval(op_e'($urandom_range(0, 1)), cur, lo, hi, $urandom_range(0, 1),
                  $urandom, idle, wall);
        burst--;
        sent++;
      end
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks at the reset settings.
    send_eval(OpForcedUp, 24'd1000000, 24'd300000, 24'd1000000, 0, 8'd5, 0, 0);
    send_eval(OpForcedUp, 24'd500000, 24'd300000, 24'd1500000, 0, 8'd0, 0, 0);
    send_eval(OpForcedUp, 24'd500000, 24'd300000, 24'd1500000, 0, 8'd1, 0, 0);
    send_eval(OpForcedUp, 24'd500000, 24'd300000, 24'd1500000, 0, 8'd2, 0, 0);
    send_eval(OpForcedUp, 24'd1200000, 24'd300000, 24'd1500000, 0, 8'd255, 0, 0);
    send_eval(OpForcedUp, 24'd500000, 24'd300000, 24'd1500000, 1, 8'd9, 0, 0);
    send_eval(OpEvaluate, 24'd300000, 24'd300000, 24'd1500000, 0, 8'd3, 0, 32'd90000);
    send_eval(OpEvaluate, 24'd800000, 24'd300000, 24'd1500000, 0, 8'd3, 0, 32'd47999);
    send_eval(OpEvaluate, 24'd800000, 24'd300000, 24'd1500000, 0, 8'd3, 0, 32'd0);
    send_eval(OpEvaluate, 24'd800000, 24'd300000, 24'd1500000, 0, 8'd3, 32'd90001,
              32'd90000);
    send_eval(OpEvaluate, 24'd1400000, 24'd100000, 24'd1500000, 0, 8'd3, 32'd85000,
              32'd90000);
    send_eval(OpEvaluate, 24'd150000, 24'd100000, 24'd1500000, 0, 8'd3, 32'd85000,
              32'd90000);
    send_eval(OpEvaluate, 24'd800000, 24'd300000, 24'd1500000, 0, 8'd3, 32'd1000,
              32'd90000);
    send_eval(OpEvaluate, 24'd800000, 24'd300000, 24'd1500000, 0, 8'd3, 32'd45000,
              32'd90000);
    send_eval(OpEvaluate, 24'd800000, 24'd100000, 24'd1500000, 1, 8'd3, 32'd1000,
              32'd90000);
    send_eval(OpEvaluate, 24'd200000, 24'd100000, 24'd1500000, 1, 8'd3, 32'd45000,
              32'd90000);
    send_eval(OpEvaluate, 24'd800000, 24'd1200000, 24'd600000, 0, 8'd3, 32'd1000,
              32'd90000);
    send_eval(OpEvaluate, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 1, 8'hFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_eval(OpForcedUp, 24'hFFFFFE, 24'hFFFFFF, 24'hFFFFFF, 1, 8'hFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_eval(OpEvaluate, 24'd0, 24'd0, 24'd0, 0, 8'd0, 32'd0, 32'd0);
    s_axis_tvalid <= 1'b0;
    random_burst(ItemsPerPhase - 20);

    // Low extremes: every step, cap and limit disabled.
    load_settings(1000, 0, 0, 0, 0, 100, 99);
    random_burst(ItemsPerPhase);
    // High extremes within range.
    load_settings(100000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 1);
    random_burst(ItemsPerPhase);
    // Full register widths, percentages beyond 100.
    load_settings(27'h7FFFFFF, 27'h7FFFFFF, 27'h7FFFFFF, 27'h7FFFFFF, 27'h7FFFFFF,
                  127, 127);
    random_burst(ItemsPerPhase);
    load_settings(2000, 500000, 300000, 50000, 100000, 80, 20);
    random_burst(ItemsPerPhase);
    load_settings($urandom_range(1000, 200000), $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(1, 100), $urandom_range(1, 99));
    random_burst(ItemsPerPhase);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lgov_pkg.sv
rtl/lgov_div_stage.sv
rtl/lgov_scale.sv
rtl/dvfs_load_governor_step_core.sv
tb/dvfs_load_governor_step_checker.sv
tb/tb_dvfs_load_governor_step_core.sv
